@@ rtl/core/cpf_pkg.sv @@
// shared constants and types for the crc8 packet forwarder
// no dependencies
`timescale 1ns / 1ps

package cpf_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam logic [7:0] CRC_POLY      = 8'h9b;
    localparam logic [7:0] PROTO_VERSION = 8'd5;
    localparam logic [7:0] DEBOUNCE_MS   = 8'd10;

    // stream item kinds
    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_BUTTON = 2'd2;

    // opcodes answered locally
    localparam logic [7:0] OP_ECHO     = 8'd100;
    localparam logic [7:0] OP_PRESSES  = 8'd101;
    localparam logic [7:0] OP_UID_LOW  = 8'd102;
    localparam logic [7:0] OP_UID_HIGH = 8'd103;

    // configuration register indexes
    localparam logic [1:0] REG_OWN_ADDRESS = 2'd0;
    localparam logic [1:0] REG_UID_LOW     = 2'd1;
    localparam logic [1:0] REG_UID_HIGH    = 2'd2;

    // frame byte positions
    localparam logic [POS_W-1:0] POS_TO      = POS_W'(1);
    localparam logic [POS_W-1:0] POS_FROM    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_VERSION = POS_W'(3);
    localparam logic [POS_W-1:0] POS_HOPS    = POS_W'(4);
    localparam logic [POS_W-1:0] POS_OPCODE  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_DATA0   = POS_W'(6);
    localparam logic [POS_W-1:0] POS_DATA7   = POS_W'(13);
    localparam logic [POS_W-1:0] POS_CRC     = POS_W'(14);
    localparam logic [POS_W-1:0] POS_END     = POS_W'(15);

    // control from the sequencer to the crc unit
    typedef struct packed {
        logic       clear;
        logic       step;
        logic [7:0] din;
    } crc_ctl_t;

endpackage

@@ rtl/core/crc8_packet_forwarder_top.sv @@
// top level of the crc8 packet forwarder: frame store, sequencer, output register
// depends on cpf_pkg and cpf_crc_unit
`timescale 1ns / 1ps

// channel   | direction | tdata         | tuser    | tlast
// ----------+-----------+---------------+----------+------------------
// s_        | in        | byte_value[8] | cmd[2]   | -
// m_        | out       | out_byte[8]   | led[1]   | last byte of frame
// cfg_      | in        | register data, up to 64 bits, index in cfg_index
//
// bytes, ticks and button edges are accepted back to back while s_tready is high. after the
// sixteenth byte of a frame the block drops s_tready: the check state runs the stored
// payload (positions 1..13) through the byte-wide crc unit, the decide state follows,
// then the send state emits all 16 bytes, stalling while m_tready is low, and reuses the
// same unit for the fresh crc. a dropped frame skips the send state. reset is synchronous
// and active low; the frame store is not cleared.

module crc8_packet_forwarder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // [0] led
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int PW = cpf_pkg::POS_W;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_CHECK,
        ST_DECIDE,
        ST_SEND
    } state_t;

    // configuration registers
    logic [7:0]  own_address_reg;
    logic [63:0] uid_low_reg;
    logic [31:0] uid_high_reg;

    // frame store, written one byte per transaction
    logic [7:0] frame_store [cpf_pkg::FRAME_BYTES];

    // sequencer and counters
    state_t      state_reg,       state_next;
    logic [PW-1:0] pos_reg,       pos_next;    // receive position
    logic [PW-1:0] idx_reg,       idx_next;    // check / send position
    logic        fwd_reg,         fwd_next;    // forward rather than reply
    logic [7:0]  press_count_reg, press_count_next;
    logic [7:0]  since_press_reg, since_press_next;
    logic        led_reg,         led_next;

    // output register, led level travels with its byte
    logic        m_valid_reg,     m_valid_next;
    logic [7:0]  m_data_reg,      m_data_next;
    logic        m_last_reg,      m_last_next;
    logic        m_led_reg,       m_led_next;

    cpf_pkg::crc_ctl_t crc_ctl;
    logic [7:0]        crc;

    logic       s_fire;
    logic       out_free;
    logic [7:0] send_byte;
    logic [2:0] data_sel;
    logic [7:0] opcode;
    logic       frame_ok;
    logic       op_known;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_RECV);
    assign out_free = !m_valid_reg || m_tready;
    assign opcode   = frame_store[cpf_pkg::POS_OPCODE];

    cpf_crc_unit u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (crc_ctl),
        .crc     (crc)
    );

    // header check once the crc of the stored payload is in
    assign frame_ok = (crc == frame_store[cpf_pkg::POS_CRC])
                   && (frame_store[cpf_pkg::POS_TO] != 8'd0)
                   && (frame_store[cpf_pkg::POS_FROM] == 8'd0)
                   && (frame_store[cpf_pkg::POS_VERSION] == cpf_pkg::PROTO_VERSION);

    assign op_known = opcode inside {cpf_pkg::OP_ECHO, cpf_pkg::OP_PRESSES,
                                     cpf_pkg::OP_UID_LOW, cpf_pkg::OP_UID_HIGH};

    // data byte number for positions 6..13
    assign data_sel = 3'(idx_reg - cpf_pkg::POS_DATA0);

    // payload byte at send position idx_reg
    always_comb begin
        send_byte = 8'd0;
        if (idx_reg == cpf_pkg::POS_CRC) begin
            send_byte = crc;
        end else if (idx_reg == cpf_pkg::POS_END || idx_reg == '0) begin
            send_byte = 8'd0;
        end else if (fwd_reg) begin
            send_byte = frame_store[idx_reg];
            if (idx_reg == cpf_pkg::POS_HOPS) begin
                send_byte = frame_store[idx_reg] + 8'd1;
            end
        end else begin
            case (idx_reg)
                cpf_pkg::POS_TO:      send_byte = 8'd0;
                cpf_pkg::POS_FROM:    send_byte = own_address_reg;
                cpf_pkg::POS_VERSION: send_byte = cpf_pkg::PROTO_VERSION;
                cpf_pkg::POS_HOPS:    send_byte = 8'd0;
                cpf_pkg::POS_OPCODE:  send_byte = opcode;
                default: begin
                    // reply data bytes
                    case (opcode)
                        cpf_pkg::OP_ECHO: send_byte = frame_store[idx_reg];
                        cpf_pkg::OP_PRESSES: begin
                            send_byte = (data_sel == 3'd7) ? press_count_reg : 8'd0;
                        end
                        cpf_pkg::OP_UID_LOW: send_byte = uid_low_reg[data_sel*8 +: 8];
                        cpf_pkg::OP_UID_HIGH: begin
                            send_byte = data_sel[2] ? 8'd0
                                      : uid_high_reg[data_sel[1:0]*8 +: 8];
                        end
                        default: send_byte = 8'd0;
                    endcase
                end
            endcase
        end
    end

    // next-state logic
    always_comb begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        idx_next         = idx_reg;
        fwd_next         = fwd_reg;
        press_count_next = press_count_reg;
        since_press_next = since_press_reg;
        led_next         = led_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;
        m_led_next       = m_led_reg;
        crc_ctl          = '{clear: 1'b0, step: 1'b0, din: frame_store[idx_reg]};

        // output transaction taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_RECV: begin
                if (s_fire) begin
                    case (s_tuser)
                        cpf_pkg::CMD_BYTE: begin
                            if (pos_reg == cpf_pkg::POS_END) begin
                                pos_next      = '0;
                                idx_next      = cpf_pkg::POS_TO;
                                crc_ctl.clear = 1'b1;
                                state_next    = ST_CHECK;
                            end else begin
                                pos_next = pos_reg + PW'(1);
                            end
                        end
                        cpf_pkg::CMD_TICK: begin
                            if (since_press_reg != 8'hff) begin
                                since_press_next = since_press_reg + 8'd1;
                            end
                        end
                        cpf_pkg::CMD_BUTTON: begin
                            if (since_press_reg > cpf_pkg::DEBOUNCE_MS) begin
                                press_count_next = press_count_reg + 8'd1;
                                since_press_next = 8'd0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_CHECK: begin
                // one stored payload byte per cycle through the crc unit
                crc_ctl.step = 1'b1;
                if (idx_reg == cpf_pkg::POS_DATA7) begin
                    state_next = ST_DECIDE;
                end else begin
                    idx_next = idx_reg + PW'(1);
                end
            end

            ST_DECIDE: begin
                crc_ctl.clear = 1'b1;
                idx_next      = '0;
                fwd_next      = (frame_store[cpf_pkg::POS_TO] != own_address_reg);
                if (!frame_ok) begin
                    state_next = ST_RECV;
                end else if (frame_store[cpf_pkg::POS_TO] != own_address_reg) begin
                    state_next = ST_SEND;
                end else if (op_known) begin
                    if (opcode == cpf_pkg::OP_ECHO) begin
                        led_next = (frame_store[cpf_pkg::POS_DATA7] != 8'd0);
                    end
                    state_next = ST_SEND;
                end else begin
                    state_next = ST_RECV;
                end
            end

            ST_SEND: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = send_byte;
                    m_last_next  = (idx_reg == cpf_pkg::POS_END);
                    m_led_next   = led_reg;
                    // fresh crc follows the bytes as they leave
                    crc_ctl.din  = send_byte;
                    crc_ctl.step = idx_reg inside {[cpf_pkg::POS_TO:cpf_pkg::POS_DATA7]};
                    if (idx_reg == cpf_pkg::POS_END) begin
                        if (!fwd_reg && opcode == cpf_pkg::OP_PRESSES) begin
                            press_count_next = 8'd0;
                        end
                        state_next = ST_RECV;
                    end else begin
                        idx_next = idx_reg + PW'(1);
                    end
                end
            end

            default: state_next = ST_RECV;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_RECV;
            pos_reg         <= '0;
            idx_reg         <= '0;
            fwd_reg         <= 1'b0;
            press_count_reg <= '0;
            since_press_reg <= '0;
            led_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_last_reg      <= 1'b0;
            m_led_reg       <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            idx_reg         <= idx_next;
            fwd_reg         <= fwd_next;
            press_count_reg <= press_count_next;
            since_press_reg <= since_press_next;
            led_reg         <= led_next;
            m_valid_reg     <= m_valid_next;
            m_last_reg      <= m_last_next;
            m_led_reg       <= m_led_next;
        end
        m_data_reg <= m_data_next;
    end

    // frame store writes
    always_ff @(posedge aclk) begin
        if (s_fire && s_tuser == cpf_pkg::CMD_BYTE) begin
            frame_store[pos_reg] <= s_tdata;
        end
    end

    // configuration writes, index 3 is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= 8'd1;
            uid_low_reg     <= '0;
            uid_high_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                cpf_pkg::REG_OWN_ADDRESS: own_address_reg <= cfg_data[7:0];
                cpf_pkg::REG_UID_LOW:     uid_low_reg     <= cfg_data;
                cpf_pkg::REG_UID_HIGH:    uid_high_reg    <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_led_reg;

endmodule

@@ rtl/core/cpf_crc_unit.sv @@
// byte-wide crc-8 accumulator (poly 0x9b, msb first), shared by check and send
// depends on cpf_pkg
`timescale 1ns / 1ps

module cpf_crc_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  cpf_pkg::crc_ctl_t ctl,
    output logic [7:0]        crc
);

    logic [7:0] crc_reg;
    logic [7:0] crc_next;

    always_comb begin
        logic [7:0] r;
        r = crc_reg ^ ctl.din;
        for (int b = 0; b < 8; b++) begin
            if (r[7]) begin
                r = {r[6:0], 1'b0} ^ cpf_pkg::CRC_POLY;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        crc_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
        end else if (ctl.clear) begin
            crc_reg <= '0;
        end else if (ctl.step) begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule
